FILE: rtl/core/emap_pkg.sv
// Package for the extent map block: sizes, command and status codes,
// and the structs shared by the cell row and the top level. No dependencies.
package emap_pkg;
   localparam int ENTRIES    = 64;
   localparam int UNIT_SHIFT = 12;
   localparam int PAGE_BITS  = 12;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);

   localparam logic [2:0] CMD_ADD   = 3'd0;
   localparam logic [2:0] CMD_FIND  = 3'd1;
   localparam logic [2:0] CMD_REM   = 3'd2;
   localparam logic [2:0] CMD_CLR   = 3'd3;
   localparam logic [2:0] CMD_EVICT = 3'd4;

   localparam logic [3:0] ST_INSERTED  = 4'd0;
   localparam logic [3:0] ST_EXTENDED  = 4'd1;
   localparam logic [3:0] ST_HIT       = 4'd2;
   localparam logic [3:0] ST_MISMATCH  = 4'd3;
   localparam logic [3:0] ST_MISALIGN  = 4'd4;
   localparam logic [3:0] ST_FULL      = 4'd5;
   localparam logic [3:0] ST_FOUND     = 4'd6;
   localparam logic [3:0] ST_NOT_FOUND = 4'd7;
   localparam logic [3:0] ST_REMOVED   = 4'd8;
   localparam logic [3:0] ST_CLEARED   = 4'd9;
   localparam logic [3:0] ST_VICTIM    = 4'd10;
   localparam logic [3:0] ST_NO_VICTIM = 4'd11;

   // q_hi is bit 40 of the lookup offset; oor flags any bit above it
   typedef struct packed {
      logic [39:0] q;
      logic        q_hi;
      logic        oor;
   } query_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic             valid_we;
      logic             valid_val;
      logic             data_we;
      logic [39:0]      start;
      logic [39:0]      coff;
      logic [7:0]       map;
      logic             dirty;
      logic             len_we;
      logic [39:0]      len;
      logic             acc_we;
      logic             acc_val;
   } wr_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic [39:0]      hit_start;
      logic [39:0]      hit_len;
      logic [39:0]      hit_coff;
      logic [7:0]       hit_map;
      logic             hit_dirty;
      logic             free;
      logic [IDX_W-1:0] free_idx;
      logic             nxt;
      logic [39:0]      nxt_start;
      logic             vic;
      logic [IDX_W-1:0] vic_idx;
      logic [39:0]      vic_start;
      logic [39:0]      vic_len;
      logic [39:0]      vic_coff;
      logic [7:0]       vic_map;
      logic             vic_dirty;
   } rec_type;
endpackage

FILE: rtl/core/emap_cell.sv
// One table slot of the extent map plus its stage of the scan record.
// Depends on emap_pkg.
module emap_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [emap_pkg::IDX_W-1:0] cell_idx,
   input  emap_pkg::query_type      query,
   input  emap_pkg::wr_type         wr,
   input  emap_pkg::rec_type        rec_in,
   output emap_pkg::rec_type        rec_out
);
   import emap_pkg::*;

   logic        valid_ff;
   logic [39:0] start_ff, len_ff, coff_ff;
   logic [7:0]  map_ff;
   logic        dirty_ff, acc_ff;
   rec_type     rec_ff, rec_in_v;
   logic [40:0] end_sum;
   logic [40:0] q_full;
   logic        hit_me, sel;

   assign end_sum = {1'b0, start_ff} + {1'b0, len_ff};
   assign q_full  = {query.q_hi, query.q};
   assign hit_me  = valid_ff && !query.oor &&
                    ({1'b0, start_ff} == q_full ||
                     ({1'b0, start_ff} < q_full && q_full < end_sum));
   assign sel     = wr.en && wr.idx == cell_idx;

   always_comb begin
      rec_in_v = rec_in;
      if (!rec_in.hit && hit_me) begin
         rec_in_v.hit       = 1'b1;
         rec_in_v.hit_idx   = cell_idx;
         rec_in_v.hit_start = start_ff;
         rec_in_v.hit_len   = len_ff;
         rec_in_v.hit_coff  = coff_ff;
         rec_in_v.hit_map   = map_ff;
         rec_in_v.hit_dirty = dirty_ff;
      end
      if (!rec_in.free && !valid_ff) begin
         rec_in_v.free     = 1'b1;
         rec_in_v.free_idx = cell_idx;
      end
      if (valid_ff && start_ff > query.q &&
          (!rec_in.nxt || start_ff < rec_in.nxt_start)) begin
         rec_in_v.nxt       = 1'b1;
         rec_in_v.nxt_start = start_ff;
      end
      if (valid_ff && !acc_ff && (!rec_in.vic || start_ff < rec_in.vic_start)) begin
         rec_in_v.vic       = 1'b1;
         rec_in_v.vic_idx   = cell_idx;
         rec_in_v.vic_start = start_ff;
         rec_in_v.vic_len   = len_ff;
         rec_in_v.vic_coff  = coff_ff;
         rec_in_v.vic_map   = map_ff;
         rec_in_v.vic_dirty = dirty_ff;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in_v;
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel && wr.valid_we) begin
         valid_ff <= wr.valid_val;
      end
      if (sel && wr.data_we) begin
         start_ff <= wr.start;
         coff_ff  <= wr.coff;
         map_ff   <= wr.map;
         dirty_ff <= wr.dirty;
      end
      if (sel && wr.len_we) begin
         len_ff <= wr.len;
      end
      if (sel && wr.acc_we) begin
         acc_ff <= wr.acc_val;
      end
   end

   assign rec_out = rec_ff;
endmodule

FILE: rtl/core/extent_map_with_access_victim_top.sv
// Top level of the extent map: command controller, CSR port and the row
// of emap_cell slots. Depends on emap_pkg and emap_cell.
//
// Usage: drive req_* and pulse start while busy is low; the transaction is
// taken at that edge. The query is broadcast to all slots while a scan
// record walks the cell row one slot per cycle, collecting the first hit,
// the first free slot, the next greater start and the evict candidate.
// After the scan comes the update state S_DONE; rsp_valid and the result
// outputs are registered from it. One transaction at a time: busy stays
// high until the result cycle, so a new transaction is taken only after the
// last one has finished its scan and update.
// The receiver cannot stall; each result is valid for exactly one cycle.
// Reset (synchronous, active high) empties the table, zeroes the count and
// sets block_shift to 12. CSR: block_shift at byte address 0, pready
// always high, written on psel & penable & pwrite.
module extent_map_with_access_victim_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [39:0] req_file_offset,
   input  logic [39:0] req_extent_length,
   input  logic [39:0] req_cache_offset,
   input  logic [7:0]  req_mapping_tag,
   input  logic [27:0] req_block_index,
   output logic        rsp_valid,
   output logic [3:0]  rsp_status,
   output logic [39:0] rsp_entry_offset,
   output logic [39:0] rsp_entry_length,
   output logic [39:0] rsp_entry_cache_offset,
   output logic [7:0]  rsp_entry_mapping,
   output logic        rsp_entry_dirty,
   output logic [27:0] rsp_freed_pages,
   output logic [6:0]  rsp_entry_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [0:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import emap_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [4:0]       shift_ff;
   logic [2:0]       cmd_ff;
   logic [39:0]      off_ff, len_ff, coff_ff;
   logic [7:0]       map_ff;
   query_type        query_ff, query_in;
   logic [58:0]      wide_off;
   wr_type           wr;
   rec_type          rec_bus [0:ENTRIES];
   rec_type          r;

   logic        rv_in;
   logic [3:0]  st_in;
   logic [39:0] eo_in, el_in, ec_in;
   logic [7:0]  em_in;
   logic        ed_in;
   logic [27:0] fp_in;
   logic        rsp_valid_ff;
   logic [3:0]  st_ff;
   logic [39:0] eo_ff, el_ff, ec_ff;
   logic [7:0]  em_ff;
   logic        ed_ff;
   logic [27:0] fp_ff;
   logic [6:0]  ecnt_ff;

   logic [40:0] end_sum;
   logic [39:0] trim_len;
   logic        misalign, mism;

   assign pready = 1'b1;
   assign prdata = (paddr == 1'b0) ? {27'd0, shift_ff} : 32'd0;
   assign busy   = state_ff != S_IDLE;

   assign wide_off = 59'(req_block_index) << shift_ff;

   always_comb begin
      query_in = query_ff;
      if (req_cmd == CMD_CLR) begin
         query_in.q    = wide_off[39:0];
         query_in.q_hi = wide_off[40];
         query_in.oor  = |wide_off[58:41];
      end else begin
         query_in.q    = req_file_offset;
         query_in.q_hi = 1'b0;
         query_in.oor  = 1'b0;
      end
   end

   assign rec_bus[0] = '0;
   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         emap_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .cell_idx(IDX_W'(g)),
            .query   (query_ff),
            .wr      (wr),
            .rec_in  (rec_bus[g]),
            .rec_out (rec_bus[g+1])
         );
      end
   endgenerate

   assign r        = rec_bus[ENTRIES];
   assign end_sum  = {1'b0, off_ff} + {1'b0, len_ff};
   assign trim_len = (r.nxt && end_sum > {1'b0, r.nxt_start}) ?
                     (r.nxt_start - off_ff) : len_ff;
   assign misalign = (off_ff[UNIT_SHIFT-1:0] != '0) || (len_ff[UNIT_SHIFT-1:0] != '0);
   assign mism     = r.hit_start != off_ff || r.hit_len > len_ff ||
                     r.hit_coff != coff_ff || r.hit_map != map_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      count_in = count_ff;
      wr       = '0;
      rv_in    = 1'b0;
      st_in    = ST_NOT_FOUND;
      eo_in    = '0;
      el_in    = '0;
      ec_in    = '0;
      em_in    = '0;
      ed_in    = 1'b0;
      fp_in    = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
               cnt_in   = '0;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
            rv_in    = 1'b1;
            if (r.hit) begin
               eo_in = r.hit_start;
               el_in = r.hit_len;
               ec_in = r.hit_coff;
               em_in = r.hit_map;
               ed_in = r.hit_dirty;
            end
            wr.idx = r.hit_idx;
            case (cmd_ff)
               CMD_ADD: begin
                  if (misalign) begin
                     st_in = ST_MISALIGN;
                     {eo_in, el_in, ec_in, em_in, ed_in} = '0;
                  end else if (r.hit) begin
                     wr.en      = 1'b1;
                     wr.acc_we  = 1'b1;
                     wr.acc_val = 1'b1;
                     if (mism) begin
                        st_in = ST_MISMATCH;
                     end else if (r.hit_len < len_ff) begin
                        st_in     = ST_EXTENDED;
                        wr.len_we = 1'b1;
                        wr.len    = trim_len;
                        el_in     = trim_len;
                     end else begin
                        st_in = ST_HIT;
                     end
                  end else if (count_ff >= CNT_W'(ENTRIES) || !r.free) begin
                     st_in = ST_FULL;
                  end else begin
                     st_in        = ST_INSERTED;
                     wr.en        = 1'b1;
                     wr.idx       = r.free_idx;
                     wr.valid_we  = 1'b1;
                     wr.valid_val = 1'b1;
                     wr.data_we   = 1'b1;
                     wr.start     = off_ff;
                     wr.coff      = coff_ff;
                     wr.map       = map_ff;
                     wr.dirty     = 1'b1;
                     wr.len_we    = 1'b1;
                     wr.len       = trim_len;
                     wr.acc_we    = 1'b1;
                     wr.acc_val   = 1'b1;
                     count_in     = count_ff + 1'b1;
                     eo_in        = off_ff;
                     el_in        = trim_len;
                     ec_in        = coff_ff;
                     em_in        = map_ff;
                     ed_in        = 1'b1;
                  end
               end
               CMD_FIND: begin
                  if (r.hit) begin
                     st_in = ST_FOUND;
                  end
               end
               CMD_REM: begin
                  if (r.hit) begin
                     st_in       = ST_REMOVED;
                     wr.en       = 1'b1;
                     wr.valid_we = 1'b1;
                     count_in    = count_ff - 1'b1;
                  end
               end
               CMD_CLR: begin
                  if (r.hit) begin
                     st_in     = ST_CLEARED;
                     wr.en     = 1'b1;
                     wr.acc_we = 1'b1;
                  end
               end
               CMD_EVICT: begin
                  if (r.vic) begin
                     st_in       = ST_VICTIM;
                     wr.en       = 1'b1;
                     wr.idx      = r.vic_idx;
                     wr.valid_we = 1'b1;
                     count_in    = count_ff - 1'b1;
                     eo_in       = r.vic_start;
                     el_in       = r.vic_len;
                     ec_in       = r.vic_coff;
                     em_in       = r.vic_map;
                     ed_in       = r.vic_dirty;
                     fp_in       = 28'(r.vic_len >> PAGE_BITS);
                  end else begin
                     st_in = ST_NO_VICTIM;
                     {eo_in, el_in, ec_in, em_in, ed_in} = '0;
                  end
               end
               default: begin
                  st_in = ST_NOT_FOUND;
                  {eo_in, el_in, ec_in, em_in, ed_in} = '0;
               end
            endcase
            if (st_in == ST_NOT_FOUND) begin
               {eo_in, el_in, ec_in, em_in, ed_in} = '0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         shift_ff     <= 5'd12;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rv_in;
         if (psel && penable && pwrite && pready && paddr == 1'b0) begin
            shift_ff <= pwdata[4:0];
         end
      end
      cnt_ff <= cnt_in;
      if (state_ff == S_IDLE && start) begin
         cmd_ff   <= req_cmd;
         off_ff   <= req_file_offset;
         len_ff   <= req_extent_length;
         coff_ff  <= req_cache_offset;
         map_ff   <= req_mapping_tag;
         query_ff <= query_in;
      end
      if (rv_in) begin
         st_ff   <= st_in;
         eo_ff   <= eo_in;
         el_ff   <= el_in;
         ec_ff   <= ec_in;
         em_ff   <= em_in;
         ed_ff   <= ed_in;
         fp_ff   <= fp_in;
         ecnt_ff <= 7'(count_in);
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = st_ff;
   assign rsp_entry_offset       = eo_ff;
   assign rsp_entry_length       = el_ff;
   assign rsp_entry_cache_offset = ec_ff;
   assign rsp_entry_mapping      = em_ff;
   assign rsp_entry_dirty        = ed_ff;
   assign rsp_freed_pages        = fp_ff;
   assign rsp_entry_count        = ecnt_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count above table size");

   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DONE))
      else $error("result without update cycle");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");
endmodule

FILE: tb/sv/testbench.sv
// Testbench for extent_map_with_access_victim_top: directed and random command
// streams checked against an in-bench model of the extent table.
// Depends on emap_pkg and the extent map RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import emap_pkg::*;

   typedef struct {
      logic [2:0]  cmd;
      logic [39:0] off;
      logic [39:0] len;
      logic [39:0] coff;
      logic [7:0]  tag;
      logic [27:0] bidx;
   } map_cmd_type;

   typedef struct {
      logic [3:0]  status;
      logic [39:0] offset;
      logic [39:0] length;
      logic [39:0] coff;
      logic [7:0]  mapping;
      logic        dirty;
      logic [27:0] freed;
      logic [6:0]  count;
   } map_rsp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_cmd = '0;
   logic [39:0] req_file_offset = '0;
   logic [39:0] req_extent_length = '0;
   logic [39:0] req_cache_offset = '0;
   logic [7:0]  req_mapping_tag = '0;
   logic [27:0] req_block_index = '0;
   logic        rsp_valid;
   logic [3:0]  rsp_status;
   logic [39:0] rsp_entry_offset;
   logic [39:0] rsp_entry_length;
   logic [39:0] rsp_entry_cache_offset;
   logic [7:0]  rsp_entry_mapping;
   logic        rsp_entry_dirty;
   logic [27:0] rsp_freed_pages;
   logic [6:0]  rsp_entry_count;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [0:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   extent_map_with_access_victim_top dut (.*);

   always #2 clock = ~clock;

   // table model
   logic        tbl_valid [ENTRIES];
   logic [63:0] tbl_start [ENTRIES];
   logic [63:0] tbl_len   [ENTRIES];
   logic [39:0] tbl_coff  [ENTRIES];
   logic [7:0]  tbl_map   [ENTRIES];
   logic        tbl_dirty [ENTRIES];
   logic        tbl_acc   [ENTRIES];
   int          tbl_count = 0;
   logic [4:0]  shift_cfg = 5'd12;

   map_rsp_type pending_rsp[$];
   int          errors = 0;
   int          idle_pct = 0;

   function automatic int find_slot(logic [63:0] q);
      for (int i = 0; i < ENTRIES; i++)
         if (tbl_valid[i] && (tbl_start[i] == q ||
             (tbl_start[i] < q && q < tbl_start[i] + tbl_len[i])))
            return i;
      return -1;
   endfunction

   function automatic void trim_slot(int s);
      logic        have = 0;
      logic [63:0] nxt = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (tbl_valid[i] && i != s && tbl_start[i] > tbl_start[s] &&
             (!have || tbl_start[i] < nxt)) begin
            nxt = tbl_start[i];
            have = 1;
         end
      if (have && tbl_start[s] + tbl_len[s] > nxt) tbl_len[s] = nxt - tbl_start[s];
   endfunction

   function automatic void show_slot(int s, ref map_rsp_type r);
      r.offset = tbl_start[s][39:0];
      r.length = tbl_len[s][39:0];
      r.coff = tbl_coff[s];
      r.mapping = tbl_map[s];
      r.dirty = tbl_dirty[s];
   endfunction

   function automatic map_rsp_type apply_cmd(map_cmd_type c);
      map_rsp_type r = '{default: '0};
      int          s = -1;
      logic [63:0] unit_mask = (64'd1 << UNIT_SHIFT) - 1;
      r.status = ST_NOT_FOUND;
      case (c.cmd)
         CMD_ADD: begin
            if ((({24'd0, c.off} | {24'd0, c.len}) & unit_mask) != 0) r.status = ST_MISALIGN;
            else begin
               s = find_slot({24'd0, c.off});
               if (s >= 0) begin
                  tbl_acc[s] = 1;
                  if (tbl_start[s] != c.off || tbl_len[s] > c.len || tbl_coff[s] != c.coff ||
                      tbl_map[s] != c.tag)
                     r.status = ST_MISMATCH;
                  else if (tbl_len[s] < c.len) begin
                     tbl_len[s] = {24'd0, c.len};
                     trim_slot(s);
                     r.status = ST_EXTENDED;
                  end else r.status = ST_HIT;
                  show_slot(s, r);
               end else begin
                  for (int i = 0; i < ENTRIES && s < 0; i++) if (!tbl_valid[i]) s = i;
                  if (s < 0) r.status = ST_FULL;
                  else begin
                     tbl_valid[s] = 1;
                     tbl_start[s] = {24'd0, c.off};
                     tbl_len[s] = {24'd0, c.len};
                     tbl_coff[s] = c.coff;
                     tbl_map[s] = c.tag;
                     tbl_dirty[s] = 1;
                     tbl_acc[s] = 1;
                     tbl_count++;
                     trim_slot(s);
                     show_slot(s, r);
                     r.status = ST_INSERTED;
                  end
               end
            end
         end
         CMD_FIND, CMD_REM: begin
            s = find_slot({24'd0, c.off});
            if (s >= 0) begin
               show_slot(s, r);
               if (c.cmd == CMD_FIND) r.status = ST_FOUND;
               else begin
                  tbl_valid[s] = 0;
                  tbl_count--;
                  r.status = ST_REMOVED;
               end
            end
         end
         CMD_CLR: begin
            s = find_slot({36'd0, c.bidx} << shift_cfg);
            if (s >= 0) begin
               tbl_acc[s] = 0;
               show_slot(s, r);
               r.status = ST_CLEARED;
            end
         end
         CMD_EVICT: begin
            for (int i = 0; i < ENTRIES; i++)
               if (tbl_valid[i] && !tbl_acc[i] && (s < 0 || tbl_start[i] < tbl_start[s])) s = i;
            if (s >= 0) begin
               show_slot(s, r);
               r.freed = 28'(tbl_len[s] >> PAGE_BITS);
               tbl_valid[s] = 0;
               tbl_count--;
               r.status = ST_VICTIM;
            end else r.status = ST_NO_VICTIM;
         end
         default: ;
      endcase
      r.count = 7'(tbl_count);
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         map_rsp_type e;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected transaction status %0d", $time, rsp_status);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_status !== e.status || rsp_entry_offset !== e.offset ||
                rsp_entry_length !== e.length || rsp_entry_cache_offset !== e.coff ||
                rsp_entry_mapping !== e.mapping || rsp_entry_dirty !== e.dirty ||
                rsp_freed_pages !== e.freed || rsp_entry_count !== e.count) begin
               $display("%0t: expected st=%0d off=%h len=%h coff=%h map=%h d=%b fp=%h cnt=%0d",
                        $time, e.status, e.offset, e.length, e.coff, e.mapping, e.dirty,
                        e.freed, e.count);
               $display("%0t: actual   st=%0d off=%h len=%h coff=%h map=%h d=%b fp=%h cnt=%0d",
                        $time, rsp_status, rsp_entry_offset, rsp_entry_length,
                        rsp_entry_cache_offset, rsp_entry_mapping, rsp_entry_dirty,
                        rsp_freed_pages, rsp_entry_count);
               errors++;
            end
         end
      end
   end

   // called right after a rising edge
   task automatic send_cmd(map_cmd_type c);
      req_cmd <= c.cmd;
      req_file_offset <= c.off;
      req_extent_length <= c.len;
      req_cache_offset <= c.coff;
      req_mapping_tag <= c.tag;
      req_block_index <= c.bidx;
      start <= 1;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(apply_cmd(c));
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 90)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
   endtask

   task automatic write_shift(logic [4:0] v);
      psel <= 1;
      pwrite <= 1;
      paddr <= '0;
      pwdata <= {27'd0, v};
      penable <= 0;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      shift_cfg = v;
   endtask

   function automatic map_cmd_type mk(logic [2:0] cmd, logic [39:0] off, logic [39:0] len,
                                      logic [39:0] coff, logic [7:0] tag, logic [27:0] bidx);
      map_cmd_type c;
      c.cmd = cmd; c.off = off; c.len = len; c.coff = coff; c.tag = tag; c.bidx = bidx;
      return c;
   endfunction

   function automatic logic [39:0] rnd40();
      return 40'({$urandom(), $urandom()});
   endfunction

   function automatic map_cmd_type rand_cmd();
      map_cmd_type c;
      int          r = $urandom_range(99);
      logic [39:0] base;
      c = mk(3'($urandom_range(4)), rnd40(), rnd40(), rnd40(), 8'($urandom()),
             28'($urandom()));
      base = ($urandom_range(9) == 0) ? 40'hFF_FFF0_0000 : 40'd0;
      c.off = base + (40'($urandom_range(255)) << UNIT_SHIFT);
      if (r < 40) begin
         c.cmd = CMD_ADD;
         c.len = 40'($urandom_range(16)) << UNIT_SHIFT;
         if ($urandom_range(4) != 0) begin
            c.coff = c.off;
            c.tag = 8'($urandom_range(1));
         end
      end else if (r < 55) c.cmd = CMD_FIND;
      else if (r < 65) c.cmd = CMD_REM;
      else if (r < 78) begin
         c.cmd = CMD_CLR;
         if ($urandom_range(9) != 0) c.bidx = 28'(c.off >> shift_cfg);
      end else if (r < 90) c.cmd = CMD_EVICT;
      else if (r < 95) begin
         c.cmd = CMD_ADD;
         c.off = rnd40();
         if ($urandom_range(1)) c.off[UNIT_SHIFT-1:0] = '0;
      end else c.cmd = 3'($urandom_range(5, 7));
      return c;
   endfunction

   task automatic test_directed();
      send_cmd(mk(CMD_ADD, 40'h1000, 40'h2000, 40'hAB000, 8'h11, 0));
      send_cmd(mk(CMD_ADD, 40'h5800, 40'h1000, 0, 0, 0));
      send_cmd(mk(CMD_ADD, 40'h5000, 40'h1001, 0, 0, 0));
      send_cmd(mk(CMD_ADD, 40'h1000, 40'h2000, 40'hAB000, 8'h11, 0));
      send_cmd(mk(CMD_ADD, 40'h1000, 40'h1000, 40'hAB000, 8'h11, 0));
      send_cmd(mk(CMD_ADD, 40'h1000, 40'h3000, 40'hAB000, 8'h22, 0));
      send_cmd(mk(CMD_ADD, 40'h2000, 40'h3000, 40'hAB000, 8'h11, 0));
      send_cmd(mk(CMD_ADD, 40'h6000, 40'h1000, 40'hFF_FFFF_FFFF, 8'hFF, 0));
      send_cmd(mk(CMD_ADD, 40'h1000, 40'h9000, 40'hAB000, 8'h11, 0));
      send_cmd(mk(CMD_ADD, 40'h8000, 40'h0, 40'h0, 8'h0, 0));
      send_cmd(mk(CMD_FIND, 40'h8000, 0, 0, 0, 0));
      send_cmd(mk(CMD_FIND, 40'h8001, 0, 0, 0, 0));
      send_cmd(mk(CMD_FIND, 40'h2FFF, 0, 0, 0, 0));
      send_cmd(mk(CMD_EVICT, 0, 0, 0, 0, 0));
      send_cmd(mk(CMD_CLR, 0, 0, 0, 0, 28'h6));
      send_cmd(mk(CMD_CLR, 0, 0, 0, 0, 28'hFFF_FFFF));
      send_cmd(mk(CMD_EVICT, 0, 0, 0, 0, 0));
      send_cmd(mk(CMD_ADD, 40'hFF_FFFF_F000, 40'hFF_FFFF_F000, 40'hFF_FFFF_FFFF, 8'hFF, 0));
      send_cmd(mk(CMD_FIND, 40'hFF_FFFF_FFFF, 0, 0, 0, 0));
      send_cmd(mk(CMD_REM, 40'h1800, 0, 0, 0, 0));
      send_cmd(mk(CMD_REM, 40'h1800, 0, 0, 0, 0));
      send_cmd(mk(3'd5, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 8'hFF, 28'hFFF_FFFF));
      send_cmd(mk(3'd6, 0, 0, 0, 0, 0));
      send_cmd(mk(3'd7, 0, 0, 0, 0, 0));
      drain();
   endtask

   task automatic test_full_table();
      for (int i = 0; i < ENTRIES + 2; i++)
         send_cmd(mk(CMD_ADD, 40'(i) << 20, 40'h1000, 40'(i), 8'(i), 0));
      send_cmd(mk(CMD_EVICT, 0, 0, 0, 0, 0));
      for (int i = 0; i < 8; i++)
         send_cmd(mk(CMD_CLR, 0, 0, 0, 0, 28'((40'(i) << 20) >> shift_cfg)));
      for (int i = 0; i < 9; i++) send_cmd(mk(CMD_EVICT, 0, 0, 0, 0, 0));
      for (int i = 0; i < ENTRIES; i++) send_cmd(mk(CMD_REM, 40'(i) << 20, 0, 0, 0, 0));
      drain();
   endtask

   task automatic test_random(int n, int pct, logic [4:0] shift);
      write_shift(shift);
      idle_pct = pct;
      repeat (n) send_cmd(rand_cmd());
      drain();
   endtask

   initial begin
      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_full_table();
      write_shift(5'd16);
      idle_pct = 0;
      send_cmd(mk(CMD_CLR, 0, 0, 0, 0, 28'h1));
      drain();
      test_random(300, 0, 5'd12);
      test_random(300, 75, 5'd9);
      test_random(300, 33, 5'd16);
      test_random(380, 0, 5'd13);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
